[hw/rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[hw/rtl/nvlb_pkg.sv]
// types, constants and helper functions of the letterbox pixel mapper
`timescale 1ns / 1ps
`default_nettype none
package nvlb_pkg;

	localparam int OUT_SIZE   = 640;
	localparam int MAX_WIDTH  = 1920;
	localparam int MAX_HEIGHT = 1088;

	localparam int CRDW = 10;  // model image coordinate
	localparam int DIMW = 11;  // source dimension
	localparam int STRW = 13;  // stride
	localparam int NUMW = 21;  // pixel divider numerator
	localparam int QW   = 11;  // pixel divider quotient
	localparam int PRDW = 26;  // colour product
	localparam int ADDRW = 4;

	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SRC_STRIDE = 2'd2;

	localparam logic signed [17:0] Q_CR_R = 18'sd91881;
	localparam logic signed [17:0] Q_CB_G = 18'sd22544;
	localparam logic signed [17:0] Q_CR_G = 18'sd46793;
	localparam logic signed [17:0] Q_CB_B = 18'sd116130;

	typedef struct packed {
		logic [9:0] out_x;
		logic [9:0] out_y;
		logic [7:0] luma_in;
		logic [7:0] cb_in;
		logic [7:0] cr_in;
	} req_t;

	typedef struct packed {
		logic        is_pad;
		logic [22:0] luma_addr;
		logic [21:0] chroma_offset;
		logic [18:0] pixel_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} rsp_t;

	typedef struct packed {
		logic [DIMW-1:0] sw;
		logic [DIMW-1:0] sh;
		logic [CRDW-1:0] nw;
		logic [CRDW-1:0] nh;
		logic [CRDW-1:0] xp;
		logic [CRDW-1:0] yp;
		logic [CRDW-1:0] xend;
		logic [CRDW-1:0] yend;
	} geom_t;

	typedef struct packed {
		logic        is_pad;
		logic [18:0] pixel_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} side_t;

	// q16 product truncated toward zero
	function automatic logic signed [9:0] q16_trunc(input logic signed [PRDW-1:0] p);
		logic signed [PRDW-1:0] tmp;
		tmp = p + (p[PRDW-1] ? PRDW'(65535) : PRDW'(0));
		return 10'(tmp >>> 16);
	endfunction

	function automatic logic [7:0] clamp8(input logic signed [10:0] v);
		logic [7:0] r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > 11'sd255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/nvlb_geom.sv]
// sequential derivation of the letterbox content size and pads from the source size
`timescale 1ns / 1ps
`default_nettype none
module nvlb_geom (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [nvlb_pkg::DIMW-1:0]   cfg_sw,
	input  wire logic [nvlb_pkg::DIMW-1:0]   cfg_sh,
	output logic                             busy,
	output nvlb_pkg::geom_t                  geom
);

	localparam logic [3:0] GEO_LOAD = 4'd0;
	localparam logic [3:0] GEO_LAST = 4'd11;

	logic                        busy_q;
	logic [3:0]                  cnt_q;
	logic [19:0]                 rem_q;
	logic [19:0]                 dsh_q;
	logic [9:0]                  quo_q;
	logic                        wide_q;
	logic [nvlb_pkg::DIMW-1:0]   swc_q;
	logic [nvlb_pkg::DIMW-1:0]   shc_q;
	nvlb_pkg::geom_t             geom_q;

	logic [nvlb_pkg::DIMW-1:0]   swc;
	logic [nvlb_pkg::DIMW-1:0]   shc;
	logic [nvlb_pkg::CRDW-1:0]   nw;
	logic [nvlb_pkg::CRDW-1:0]   nh;
	logic [nvlb_pkg::CRDW-1:0]   xp;
	logic [nvlb_pkg::CRDW-1:0]   yp;

	always_comb begin
		if (cfg_sw == '0) begin
			swc = nvlb_pkg::DIMW'(1);
		end else if (cfg_sw > nvlb_pkg::DIMW'(nvlb_pkg::MAX_WIDTH)) begin
			swc = nvlb_pkg::DIMW'(nvlb_pkg::MAX_WIDTH);
		end else begin
			swc = cfg_sw;
		end
		if (cfg_sh == '0) begin
			shc = nvlb_pkg::DIMW'(1);
		end else if (cfg_sh > nvlb_pkg::DIMW'(nvlb_pkg::MAX_HEIGHT)) begin
			shc = nvlb_pkg::DIMW'(nvlb_pkg::MAX_HEIGHT);
		end else begin
			shc = cfg_sh;
		end
	end

	always_comb begin
		nw = wide_q ? nvlb_pkg::CRDW'(nvlb_pkg::OUT_SIZE) : quo_q;
		nh = wide_q ? quo_q : nvlb_pkg::CRDW'(nvlb_pkg::OUT_SIZE);
		xp = (nvlb_pkg::CRDW'(nvlb_pkg::OUT_SIZE) - nw) >> 1;
		yp = (nvlb_pkg::CRDW'(nvlb_pkg::OUT_SIZE) - nh) >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= GEO_LOAD;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= GEO_LOAD;
		end else if (busy_q) begin
			if (cnt_q == GEO_LAST) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 4'd1;
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			if (cnt_q == GEO_LOAD) begin
				wide_q <= (swc >= shc);
				swc_q  <= swc;
				shc_q  <= shc;
				quo_q  <= '0;
				if (swc >= shc) begin
					rem_q <= 20'(shc) * 20'(nvlb_pkg::OUT_SIZE);
					dsh_q <= 20'(swc) << 9;
				end else begin
					rem_q <= 20'(swc) * 20'(nvlb_pkg::OUT_SIZE);
					dsh_q <= 20'(shc) << 9;
				end
			end else if (cnt_q == GEO_LAST) begin
				geom_q.sw   <= swc_q;
				geom_q.sh   <= shc_q;
				geom_q.nw   <= nw;
				geom_q.nh   <= nh;
				geom_q.xp   <= xp;
				geom_q.yp   <= yp;
				geom_q.xend <= xp + nw;
				geom_q.yend <= yp + nh;
			end else begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[8:0], 1'b1};
				end else begin
					quo_q <= {quo_q[8:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
		end
	end

	assign busy = busy_q;
	assign geom = geom_q;

endmodule
`default_nettype wire

[hw/rtl/nvlb_front.sv]
// front stages: content test, divider numerators, colour products and clamping
`timescale 1ns / 1ps
`default_nettype none
module nvlb_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        valid_in,
	input  wire nvlb_pkg::req_t              req,
	input  wire nvlb_pkg::geom_t             geom,
	output logic                             valid_out,
	output logic [nvlb_pkg::NUMW-1:0]        numx,
	output logic [nvlb_pkg::NUMW-1:0]        numy,
	output nvlb_pkg::side_t                  side
);

	logic                              valid_s1;
	logic                              in_box_s1;
	logic [nvlb_pkg::NUMW-1:0]         numx_s1;
	logic [nvlb_pkg::NUMW-1:0]         numy_s1;
	logic [18:0]                       pidx_s1;
	logic [7:0]                        luma_s1;
	logic signed [nvlb_pkg::PRDW-1:0]  pr_s1;
	logic signed [nvlb_pkg::PRDW-1:0]  pgu_s1;
	logic signed [nvlb_pkg::PRDW-1:0]  pgv_s1;
	logic signed [nvlb_pkg::PRDW-1:0]  pb_s1;

	logic                              valid_s2;
	logic [nvlb_pkg::NUMW-1:0]         numx_s2;
	logic [nvlb_pkg::NUMW-1:0]         numy_s2;
	nvlb_pkg::side_t                   side_s2;

	logic                              in_box;
	logic [nvlb_pkg::CRDW-1:0]         dx;
	logic [nvlb_pkg::CRDW-1:0]         dy;
	logic signed [8:0]                 u;
	logic signed [8:0]                 v;
	logic signed [10:0]                r_sum;
	logic signed [10:0]                g_sum;
	logic signed [10:0]                b_sum;
	nvlb_pkg::side_t                   side_d;

	always_comb begin
		in_box = (req.out_x >= geom.xp) && (req.out_x < geom.xend) &&
		         (req.out_y >= geom.yp) && (req.out_y < geom.yend);
		dx = req.out_x - geom.xp;
		dy = req.out_y - geom.yp;
		u  = $signed({1'b0, req.cb_in}) - 9'sd128;
		v  = $signed({1'b0, req.cr_in}) - 9'sd128;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_box_s1 <= in_box;
			numx_s1   <= in_box ? nvlb_pkg::NUMW'(dx) * nvlb_pkg::NUMW'(geom.sw) : '0;
			numy_s1   <= in_box ? nvlb_pkg::NUMW'(dy) * nvlb_pkg::NUMW'(geom.sh) : '0;
			pidx_s1   <= 19'(req.out_y) * 19'(nvlb_pkg::OUT_SIZE) + 19'(req.out_x);
			luma_s1   <= req.luma_in;
			pr_s1     <= nvlb_pkg::PRDW'(v) * nvlb_pkg::PRDW'(nvlb_pkg::Q_CR_R);
			pgu_s1    <= nvlb_pkg::PRDW'(u) * nvlb_pkg::PRDW'(nvlb_pkg::Q_CB_G);
			pgv_s1    <= nvlb_pkg::PRDW'(v) * nvlb_pkg::PRDW'(nvlb_pkg::Q_CR_G);
			pb_s1     <= nvlb_pkg::PRDW'(u) * nvlb_pkg::PRDW'(nvlb_pkg::Q_CB_B);
		end
	end

	always_comb begin
		r_sum = $signed({3'b000, luma_s1}) + 11'(nvlb_pkg::q16_trunc(pr_s1));
		g_sum = $signed({3'b000, luma_s1}) - 11'(nvlb_pkg::q16_trunc(pgu_s1))
		        - 11'(nvlb_pkg::q16_trunc(pgv_s1));
		b_sum = $signed({3'b000, luma_s1}) + 11'(nvlb_pkg::q16_trunc(pb_s1));
		side_d.is_pad      = !in_box_s1;
		side_d.pixel_index = pidx_s1;
		side_d.red         = in_box_s1 ? nvlb_pkg::clamp8(r_sum) : 8'd0;
		side_d.green       = in_box_s1 ? nvlb_pkg::clamp8(g_sum) : 8'd0;
		side_d.blue        = in_box_s1 ? nvlb_pkg::clamp8(b_sum) : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s2 <= numx_s1;
			numy_s2 <= numy_s1;
			side_s2 <= side_d;
		end
	end

	assign valid_out = valid_s2;
	assign numx      = numx_s2;
	assign numy      = numy_s2;
	assign side      = side_s2;

endmodule
`default_nettype wire

[hw/rtl/nvlb_div.sv]
// pipelined restoring divider for source column and row, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module nvlb_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        valid_in,
	input  wire logic [nvlb_pkg::NUMW-1:0]   numx,
	input  wire logic [nvlb_pkg::NUMW-1:0]   numy,
	input  wire nvlb_pkg::side_t             side_in,
	input  wire logic [nvlb_pkg::CRDW-1:0]   den_x,
	input  wire logic [nvlb_pkg::CRDW-1:0]   den_y,
	output logic                             valid_out,
	output logic [nvlb_pkg::QW-1:0]          sx,
	output logic [nvlb_pkg::QW-1:0]          sy,
	output nvlb_pkg::side_t                  side_out
);

	logic                        vld_s   [nvlb_pkg::QW];
	logic [nvlb_pkg::NUMW-1:0]   rem_x_s [nvlb_pkg::QW];
	logic [nvlb_pkg::NUMW-1:0]   rem_y_s [nvlb_pkg::QW];
	logic [nvlb_pkg::QW-1:0]     quo_x_s [nvlb_pkg::QW];
	logic [nvlb_pkg::QW-1:0]     quo_y_s [nvlb_pkg::QW];
	nvlb_pkg::side_t             side_s  [nvlb_pkg::QW];

	for (genvar k = 0; k < nvlb_pkg::QW; k++) begin : g_stage
		localparam int B = nvlb_pkg::QW - 1 - k;

		logic                        v_d;
		logic [nvlb_pkg::NUMW-1:0]   rx_d;
		logic [nvlb_pkg::NUMW-1:0]   ry_d;
		logic [nvlb_pkg::QW-1:0]     qx_d;
		logic [nvlb_pkg::QW-1:0]     qy_d;
		nvlb_pkg::side_t             s_d;
		logic [nvlb_pkg::NUMW-1:0]   dx_sh;
		logic [nvlb_pkg::NUMW-1:0]   dy_sh;

		if (k == 0) begin : g_first
			assign v_d  = valid_in;
			assign rx_d = numx;
			assign ry_d = numy;
			assign qx_d = '0;
			assign qy_d = '0;
			assign s_d  = side_in;
		end else begin : g_next
			assign v_d  = vld_s[k-1];
			assign rx_d = rem_x_s[k-1];
			assign ry_d = rem_y_s[k-1];
			assign qx_d = quo_x_s[k-1];
			assign qy_d = quo_y_s[k-1];
			assign s_d  = side_s[k-1];
		end

		assign dx_sh = nvlb_pkg::NUMW'(den_x) << B;
		assign dy_sh = nvlb_pkg::NUMW'(den_y) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_d;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= s_d;
				if (rx_d >= dx_sh) begin
					rem_x_s[k] <= rx_d - dx_sh;
					quo_x_s[k] <= qx_d | (nvlb_pkg::QW'(1) << B);
				end else begin
					rem_x_s[k] <= rx_d;
					quo_x_s[k] <= qx_d;
				end
				if (ry_d >= dy_sh) begin
					rem_y_s[k] <= ry_d - dy_sh;
					quo_y_s[k] <= qy_d | (nvlb_pkg::QW'(1) << B);
				end else begin
					rem_y_s[k] <= ry_d;
					quo_y_s[k] <= qy_d;
				end
			end
		end
	end

	assign valid_out = vld_s[nvlb_pkg::QW-1];
	assign sx        = quo_x_s[nvlb_pkg::QW-1];
	assign sy        = quo_y_s[nvlb_pkg::QW-1];
	assign side_out  = side_s[nvlb_pkg::QW-1];

endmodule
`default_nettype wire

[hw/rtl/nvlb_back.sv]
// back stages: luma and chroma address products, sums and the output register
`timescale 1ns / 1ps
`default_nettype none
module nvlb_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        valid_in,
	input  wire logic [nvlb_pkg::QW-1:0]     sx,
	input  wire logic [nvlb_pkg::QW-1:0]     sy,
	input  wire nvlb_pkg::side_t             side,
	input  wire logic [nvlb_pkg::STRW-1:0]   stride,
	output logic                             rsp_valid,
	output nvlb_pkg::rsp_t                   rsp
);

	logic                        valid_s1;
	logic [23:0]                 prod_l_s1;
	logic [23:0]                 prod_c_s1;
	logic [nvlb_pkg::QW-1:0]     sx_s1;
	nvlb_pkg::side_t             side_s1;

	logic                        rsp_valid_q;
	nvlb_pkg::rsp_t              rsp_q;

	logic [23:0]                 luma_sum;
	logic [23:0]                 chroma_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= valid_in;
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_l_s1 <= 24'(sy) * 24'(stride);
			prod_c_s1 <= 24'(sy >> 1) * 24'(stride);
			sx_s1     <= sx;
			side_s1   <= side;
		end
	end

	always_comb begin
		luma_sum   = prod_l_s1 + 24'(sx_s1);
		// chroma pairs sit on even byte offsets
		chroma_sum = prod_c_s1 + 24'({sx_s1[nvlb_pkg::QW-1:1], 1'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.is_pad        <= side_s1.is_pad;
			rsp_q.luma_addr     <= side_s1.is_pad ? 23'd0 : luma_sum[22:0];
			rsp_q.chroma_offset <= side_s1.is_pad ? 22'd0 : chroma_sum[21:0];
			rsp_q.pixel_index   <= side_s1.pixel_index;
			rsp_q.red           <= side_s1.red;
			rsp_q.green         <= side_s1.green;
			rsp_q.blue          <= side_s1.blue;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

[hw/rtl/nv12_letterbox_rgb_pixel.sv]
// top level: register port, geometry unit and the pixel pipeline
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Maps one pixel of the 640 x 640 model image onto an NV12 source frame and converts
// the Y/Cb/Cr bytes carried with it to RGB. One item is accepted every clock while the
// pipeline is not held; the result passes 15 register stages (two front stages, an
// 11-stage divider giving one source column/row bit per stage, an address product stage
// and the output register) before rsp_valid rises, and the whole pipeline holds when
// the result is not taken. After reset and after every register write the geometry
// unit works out the content size and pads with a bit-serial divider; req_ready stays
// low while it is busy.
module nv12_letterbox_rgb_pixel (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [nvlb_pkg::ADDRW-1:0]     paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire nvlb_pkg::req_t                 req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output nvlb_pkg::rsp_t                      rsp
);

	logic [nvlb_pkg::DIMW-1:0]   width_q;
	logic [nvlb_pkg::DIMW-1:0]   height_q;
	logic [nvlb_pkg::STRW-1:0]   stride_q;

	logic                        cfg_we;
	logic                        en;
	logic                        busy;
	nvlb_pkg::geom_t             geom;

	logic                        f_valid;
	logic [nvlb_pkg::NUMW-1:0]   f_numx;
	logic [nvlb_pkg::NUMW-1:0]   f_numy;
	nvlb_pkg::side_t             f_side;
	logic                        d_valid;
	logic [nvlb_pkg::QW-1:0]     d_sx;
	logic [nvlb_pkg::QW-1:0]     d_sy;
	nvlb_pkg::side_t             d_side;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= nvlb_pkg::DIMW'(1920);
			height_q <= nvlb_pkg::DIMW'(1080);
			stride_q <= nvlb_pkg::STRW'(1920);
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				nvlb_pkg::REG_SRC_WIDTH:  width_q  <= pwdata[nvlb_pkg::DIMW-1:0];
				nvlb_pkg::REG_SRC_HEIGHT: height_q <= pwdata[nvlb_pkg::DIMW-1:0];
				nvlb_pkg::REG_SRC_STRIDE: stride_q <= pwdata[nvlb_pkg::STRW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			nvlb_pkg::REG_SRC_WIDTH:  prdata = 32'(width_q);
			nvlb_pkg::REG_SRC_HEIGHT: prdata = 32'(height_q);
			nvlb_pkg::REG_SRC_STRIDE: prdata = 32'(stride_q);
			default:                  prdata = 32'd0;
		endcase
	end

	// whole pipeline moves together unless the output item is stuck
	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en && !busy;

	nvlb_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we),
		.cfg_sw (width_q),
		.cfg_sh (height_q),
		.busy   (busy),
		.geom   (geom)
	);

	nvlb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (req_valid && req_ready),
		.req       (req),
		.geom      (geom),
		.valid_out (f_valid),
		.numx      (f_numx),
		.numy      (f_numy),
		.side      (f_side)
	);

	nvlb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (f_valid),
		.numx      (f_numx),
		.numy      (f_numy),
		.side_in   (f_side),
		.den_x     (geom.nw),
		.den_y     (geom.nh),
		.valid_out (d_valid),
		.sx        (d_sx),
		.sy        (d_sy),
		.side_out  (d_side)
	);

	nvlb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (d_valid),
		.sx        (d_sx),
		.sy        (d_sy),
		.side      (d_side),
		.stride    (stride_q),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	`ASSERT_NEVER(a_no_accept_busy, clk, arst_n, busy && req_ready)
	`ASSERT_PROP(a_write_starts_geom, clk, arst_n, cfg_we |=> busy)
	`ASSERT_PROP(a_pad_is_black, clk, arst_n, (rsp_valid && rsp.is_pad) |-> (rsp.luma_addr == 23'd0 && rsp.chroma_offset == 22'd0 && rsp.red == 8'd0 && rsp.green == 8'd0 && rsp.blue == 8'd0))

endmodule
`default_nettype wire

[dv/nvlb_pixel_checker.sv]
// checker: watches both item channels, predicts each pixel result and compares
`timescale 1ns / 1ps
`default_nettype none
module nvlb_pixel_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [nvlb_pkg::ADDRW-1:0] paddr,
	input  wire logic [31:0]     pwdata,
	input  wire logic            pready,
	input  wire logic            req_valid,
	input  wire logic            req_ready,
	input  wire nvlb_pkg::req_t  req,
	input  wire logic            rsp_valid,
	input  wire logic            rsp_ready,
	input  wire nvlb_pkg::rsp_t  rsp,
	output int                   errors,
	output int                   pending,
	output int                   pads_seen,
	output int                   pixels_seen
);

	logic [10:0] width_q, height_q;
	logic [12:0] stride_q;
	nvlb_pkg::rsp_t pixel_q[$];

	assign pending = pixel_q.size();

	function automatic int q16_toward_zero(int p);
		if (p < 0) begin
			return -((-p) >>> 16);
		end
		return p >>> 16;
	endfunction

	function automatic logic [7:0] to_byte(int v);
		if (v < 0) begin
			return 8'd0;
		end
		if (v > 255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	function automatic nvlb_pkg::rsp_t map_pixel(nvlb_pkg::req_t p);
		nvlb_pkg::rsp_t r;
		longint sw, sh, nw, nh, xp, yp, ox, oy, sx, sy;
		int y, u, v;
		r = '0;
		ox = p.out_x;
		oy = p.out_y;
		sw = width_q == 0 ? 1 : width_q;
		sh = height_q == 0 ? 1 : height_q;
		if (sw > nvlb_pkg::MAX_WIDTH) begin
			sw = nvlb_pkg::MAX_WIDTH;
		end
		if (sh > nvlb_pkg::MAX_HEIGHT) begin
			sh = nvlb_pkg::MAX_HEIGHT;
		end
		if (sw >= sh) begin
			nw = nvlb_pkg::OUT_SIZE;
			nh = sh * nvlb_pkg::OUT_SIZE / sw;
		end else begin
			nh = nvlb_pkg::OUT_SIZE;
			nw = sw * nvlb_pkg::OUT_SIZE / sh;
		end
		xp = (nvlb_pkg::OUT_SIZE - nw) / 2;
		yp = (nvlb_pkg::OUT_SIZE - nh) / 2;
		r.pixel_index = 19'(oy * nvlb_pkg::OUT_SIZE + ox);
		if (!(nw > 0 && nh > 0 && ox >= xp && ox < xp + nw && oy >= yp && oy < yp + nh)) begin
			r.is_pad = 1'b1;
			return r;
		end
		sx = (ox - xp) * sw / nw;
		sy = (oy - yp) * sh / nh;
		y = p.luma_in;
		u = int'(p.cb_in) - 128;
		v = int'(p.cr_in) - 128;
		r.luma_addr = 23'(sy * stride_q + sx);
		r.chroma_offset = 22'((sy / 2) * stride_q + (sx / 2) * 2);
		r.red = to_byte(y + q16_toward_zero(91881 * v));
		r.green = to_byte(y - q16_toward_zero(22544 * u) - q16_toward_zero(46793 * v));
		r.blue = to_byte(y + q16_toward_zero(116130 * u));
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		nvlb_pkg::rsp_t e;
		if (!arst_n) begin
			width_q <= 11'd1920;
			height_q <= 11'd1080;
			stride_q <= 13'd1920;
			errors <= 0;
			pads_seen <= 0;
			pixels_seen <= 0;
			pixel_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					nvlb_pkg::REG_SRC_WIDTH: width_q <= pwdata[10:0];
					nvlb_pkg::REG_SRC_HEIGHT: height_q <= pwdata[10:0];
					nvlb_pkg::REG_SRC_STRIDE: stride_q <= pwdata[12:0];
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				pixel_q.push_back(map_pixel(req));
			end
			if (rsp_valid && rsp_ready) begin
				if (pixel_q.size() == 0) begin
					report("unexpected item", rsp.pixel_index, -1);
				end else begin
					e = pixel_q.pop_front();
					pixels_seen <= pixels_seen + 1;
					if (e.is_pad) begin
						pads_seen <= pads_seen + 1;
					end
					if (rsp.is_pad !== e.is_pad) report("is_pad", rsp.is_pad, e.is_pad);
					if (rsp.luma_addr !== e.luma_addr)
						report("luma_addr", rsp.luma_addr, e.luma_addr);
					if (rsp.chroma_offset !== e.chroma_offset)
						report("chroma_offset", rsp.chroma_offset, e.chroma_offset);
					if (rsp.pixel_index !== e.pixel_index)
						report("pixel_index", rsp.pixel_index, e.pixel_index);
					if (rsp.red !== e.red) report("red", rsp.red, e.red);
					if (rsp.green !== e.green) report("green", rsp.green, e.green);
					if (rsp.blue !== e.blue) report("blue", rsp.blue, e.blue);
				end
			end
		end
	end
endmodule
`default_nettype wire

[dv/tb_nv12_letterbox_rgb_pixel.sv]
// testbench top: clock, reset, register writes, pixel stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_nv12_letterbox_rgb_pixel;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [nvlb_pkg::ADDRW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic req_valid, req_ready, rsp_valid, rsp_ready;
	nvlb_pkg::req_t req;
	nvlb_pkg::rsp_t rsp;
	int errors, pending, pads_seen, pixels_seen;
	int cycles;
	bit no_idle;
	int sent;

	nv12_letterbox_rgb_pixel i_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	nvlb_pixel_checker i_checker (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.errors(errors), .pending(pending), .pads_seen(pads_seen),
		.pixels_seen(pixels_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// stall pattern of the result side
	always @(negedge clk) begin
		rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 20);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("tb_nv12_letterbox_rgb_pixel failed");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= nvlb_pkg::ADDRW'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// valid stays up after the accept; the next call or drain() drops or reloads it
	task automatic send_pixel(logic [9:0] x, logic [9:0] y, logic [7:0] l, logic [7:0] cb,
			logic [7:0] cr);
		if (!no_idle) begin
			while ($urandom_range(99) < 20) begin
				req_valid <= 1'b0;
				@(negedge clk);
			end
		end
		req_valid <= 1'b1;
		req <= '{out_x: x, out_y: y, luma_in: l, cb_in: cb, cr_in: cr};
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_random(int n);
		logic [9:0] x, y;
		repeat (n) begin
			// mostly real coordinates, a few beyond the model image
			x = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(639));
			y = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(639));
			send_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		logic [31:0] geo[8][3];
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: corners, centre, beyond range, colour extremes
		send_pixel(10'd0, 10'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(10'd0, 10'd140, 8'd255, 8'd255, 8'd255);
		send_pixel(10'd639, 10'd499, 8'd255, 8'd0, 8'd255);
		send_pixel(10'd320, 10'd320, 8'd0, 8'd255, 8'd0);
		send_pixel(10'd639, 10'd639, 8'd128, 8'd128, 8'd128);
		send_pixel(10'd1023, 10'd1023, 8'd170, 8'd85, 8'd170);
		send_pixel(10'd100, 10'd1023, 8'd85, 8'd170, 8'd85);
		send_pixel(10'd319, 10'd139, 8'd16, 8'd0, 8'd255);
		send_pixel(10'd319, 10'd140, 8'd235, 8'd255, 8'd0);
		drain();

		// widths, heights, strides incl. zero, oversize and degenerate content
		geo = '{
			'{1, 1, 1}, '{0, 0, 4096}, '{2047, 2047, 8191}, '{1920, 1, 1920},
			'{1, 1088, 7}, '{640, 480, 640}, '{97, 1500, 4095}, '{1920, 1080, 1920}
		};
		foreach (geo[g]) begin
			write_reg(nvlb_pkg::REG_SRC_WIDTH, geo[g][0]);
			write_reg(nvlb_pkg::REG_SRC_HEIGHT, geo[g][1]);
			write_reg(nvlb_pkg::REG_SRC_STRIDE, geo[g][2]);
			no_idle = (g == 3);
			send_pixel(10'd0, 10'd0, 8'd255, 8'd0, 8'd255);
			send_pixel(10'd639, 10'd639, 8'd0, 8'd255, 8'd0);
			send_random(170);
			drain();
		end
		no_idle = 1'b0;
		// random geometry
		repeat (3) begin
			write_reg(nvlb_pkg::REG_SRC_WIDTH, $urandom_range(2047));
			write_reg(nvlb_pkg::REG_SRC_HEIGHT, $urandom_range(2047));
			write_reg(nvlb_pkg::REG_SRC_STRIDE, $urandom_range(8191));
			send_random(50);
			drain();
		end

		$display("covered %0d pixels over 12 frame geometry settings, %0d of them padding",
			pixels_seen, pads_seen);
		if (errors == 0) begin
			$display("tb_nv12_letterbox_rgb_pixel passed");
		end else begin
			$display("tb_nv12_letterbox_rgb_pixel failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/nvlb_pkg.sv
hw/rtl/nvlb_geom.sv
hw/rtl/nvlb_front.sv
hw/rtl/nvlb_div.sv
hw/rtl/nvlb_back.sv
hw/rtl/nv12_letterbox_rgb_pixel.sv
dv/nvlb_pixel_checker.sv
dv/tb_nv12_letterbox_rgb_pixel.sv
